// ----- src/m3i_pkg.sv -----
package m3i_pkg;

    localparam int ELEM_W = 16;
    localparam int NELEM  = 9;
    localparam int PROD_W = 32;
    localparam int ADJ_W  = 33;
    localparam int DP_W   = 49;
    localparam int DET_W  = 50;
    localparam int MAG_W  = 32;
    localparam int DEN_W  = 48;
    localparam int FRAC_SH = 24;
    localparam int NUM_W  = 56;
    localparam int QBITS  = 33;
    localparam int OUT_W  = 32;
    localparam int CMP_W  = DEN_W + QBITS;
    // precheck stage, one stage per quotient bit, saturation stage
    localparam int DIV_LAT = QBITS + 2;
    localparam int NPRE    = 6;

    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    // operand indices of the eighteen 2x2 minor products; cofactor k is
    // product 2k minus product 2k+1, with the adjugate sign folded in
    localparam int IDX_A [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam int IDX_B [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

    typedef struct packed {
        logic en;
    } pipe_ctl_t;

endpackage

// ----- src/m3i_div.sv -----
module m3i_div
    import m3i_pkg::*;
(
    input  logic             aclk,
    input  pipe_ctl_t        ctl,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic             neg,
    input  logic             sing,
    output logic [OUT_W-1:0] res,
    output logic             sing_o
);

    logic [NUM_W-1:0] rem_reg [QBITS+1];
    logic [QBITS-1:0] quo_reg [QBITS+1];
    logic [DEN_W-1:0] den_reg [QBITS+1];
    logic             neg_reg [QBITS+1];
    logic             ovf_reg [QBITS+1];
    logic             zer_reg [QBITS+1];
    logic [OUT_W-1:0] res_reg;
    logic             sout_reg;
    logic [OUT_W-1:0] res_next;
    logic             ovf_next;

    // quotient of 2^33 or more saturates whatever its sign
    assign ovf_next = {{(CMP_W-NUM_W){1'b0}}, num} >= {den, {QBITS{1'b0}}};

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            rem_reg[0] <= num;
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            neg_reg[0] <= neg;
            ovf_reg[0] <= ovf_next;
            zer_reg[0] <= sing;
        end
    end

    genvar k;
    generate
        for (k = 0; k < QBITS; k++) begin : g_bit
            logic [CMP_W-1:0] sub;
            logic             ge;
            assign sub = {{QBITS{1'b0}}, den_reg[k]} << (QBITS - 1 - k);
            assign ge  = {{(CMP_W-NUM_W){1'b0}}, rem_reg[k]} >= sub;
            always_ff @(posedge aclk) begin
                if (ctl.en) begin
                    rem_reg[k+1] <= ge ? rem_reg[k] - sub[NUM_W-1:0] : rem_reg[k];
                    quo_reg[k+1] <= {quo_reg[k][QBITS-2:0], ge};
                    den_reg[k+1] <= den_reg[k];
                    neg_reg[k+1] <= neg_reg[k];
                    ovf_reg[k+1] <= ovf_reg[k];
                    zer_reg[k+1] <= zer_reg[k];
                end
            end
        end
    endgenerate

    always_comb begin
        logic [QBITS-1:0] q;
        q = quo_reg[QBITS];
        if (zer_reg[QBITS]) begin
            res_next = '0;
        end else if (neg_reg[QBITS]) begin
            if (ovf_reg[QBITS] || q > {1'b0, SAT_NEG}) begin
                res_next = SAT_NEG;
            end else begin
                res_next = OUT_W'(-q);
            end
        end else begin
            if (ovf_reg[QBITS] || q > {1'b0, SAT_POS}) begin
                res_next = SAT_POS;
            end else begin
                res_next = q[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            res_reg  <= res_next;
            sout_reg <= zer_reg[QBITS];
        end
    end

    assign res    = res_reg;
    assign sing_o = sout_reg;

endmodule

// ----- src/matrix_3x3_inverse.sv -----
// Inverts one 3x3 matrix of signed Q8.8 elements per request by the
// adjugate method and returns the nine inverse elements in signed Q16.16,
// rounded to nearest with ties away from zero and saturated; a zero
// determinant raises the singular flag (m_tuser) and returns zeros. The
// pipeline takes one matrix every cycle while the output is not stalled;
// six stages form the products, cofactors, determinant and magnitudes,
// and a 35-stage divider per element yields one quotient bit per stage.
// When a result waits at the output the whole pipeline holds, so
// s_tready follows m_tready while the output register is full.
module matrix_3x3_inverse
    import m3i_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // a00, a01, a02, a10, a11, a12, a20, a21, a22 (16 bits each)
    input  logic [NELEM*ELEM_W-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22 (32 bits each)
    output logic [NELEM*OUT_W-1:0]  m_tdata,
    // singular
    output logic                    m_tuser
);

    localparam int NST = NPRE + DIV_LAT;

    pipe_ctl_t ctl;
    logic      vld_reg [NST];

    logic signed [ELEM_W-1:0] a_reg   [NELEM];
    logic signed [PROD_W-1:0] p_reg   [18];
    logic signed [ELEM_W-1:0] r2_reg  [3];
    logic signed [ADJ_W-1:0]  adj3_reg[NELEM];
    logic signed [ELEM_W-1:0] r3_reg  [3];
    logic signed [DP_W-1:0]   dp_reg  [3];
    logic signed [ADJ_W-1:0]  adj4_reg[NELEM];
    logic signed [DET_W-1:0]  det_reg;
    logic signed [ADJ_W-1:0]  adj5_reg[NELEM];
    logic [NUM_W-1:0]         num_reg [NELEM];
    logic [DEN_W-1:0]         den_reg;
    logic                     neg_reg [NELEM];
    logic                     sing_reg;

    logic [DET_W-1:0] det_abs;
    logic [OUT_W-1:0] res  [NELEM];
    logic             sing_o [NELEM];

    assign ctl.en   = !vld_reg[NST-1] || m_tready;
    assign s_tready = ctl.en;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tuser  = sing_o[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NST; i++) vld_reg[i] <= 1'b0;
        end else if (ctl.en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < NST; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    assign det_abs = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            for (int i = 0; i < NELEM; i++) a_reg[i] <= s_tdata[i*ELEM_W +: ELEM_W];
            // minor products
            for (int j = 0; j < 18; j++) p_reg[j] <= PROD_W'(a_reg[IDX_A[j]] * a_reg[IDX_B[j]]);
            for (int i = 0; i < 3; i++) r2_reg[i] <= a_reg[i];
            // cofactors
            for (int i = 0; i < NELEM; i++) begin
                adj3_reg[i] <= ADJ_W'(p_reg[2*i]) - ADJ_W'(p_reg[2*i+1]);
            end
            r3_reg <= r2_reg;
            // first-row expansion terms
            dp_reg[0] <= DP_W'(adj3_reg[0] * r3_reg[0]);
            dp_reg[1] <= DP_W'(adj3_reg[3] * r3_reg[1]);
            dp_reg[2] <= DP_W'(adj3_reg[6] * r3_reg[2]);
            adj4_reg  <= adj3_reg;
            det_reg   <= DET_W'(dp_reg[0]) + DET_W'(dp_reg[1]) + DET_W'(dp_reg[2]);
            adj5_reg  <= adj4_reg;
            // rounding numerator |adj| * 2^24 + floor(|det| / 2)
            for (int i = 0; i < NELEM; i++) begin
                logic [ADJ_W-1:0] mag;
                mag = adj5_reg[i][ADJ_W-1] ? ADJ_W'(-adj5_reg[i]) : ADJ_W'(adj5_reg[i]);
                num_reg[i] <= {mag[MAG_W-1:0], {FRAC_SH{1'b0}}}
                            + NUM_W'(det_abs[DEN_W-1:1]);
                neg_reg[i] <= adj5_reg[i][ADJ_W-1] ^ det_reg[DET_W-1];
            end
            den_reg  <= det_abs[DEN_W-1:0];
            sing_reg <= (det_reg == '0);
        end
    end

    genvar e;
    generate
        for (e = 0; e < NELEM; e++) begin : g_div
            m3i_div u_div (
                .aclk   (aclk),
                .ctl    (ctl),
                .num    (num_reg[e]),
                .den    (den_reg),
                .neg    (neg_reg[e]),
                .sing   (sing_reg),
                .res    (res[e]),
                .sing_o (sing_o[e])
            );
            assign m_tdata[e*OUT_W +: OUT_W] = res[e];
        end
    endgenerate

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("singular result carries nonzero elements");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctl.en |=> (vld_reg[0] == $past(vld_reg[0])) && (vld_reg[NPRE] == $past(vld_reg[NPRE])))
        else $error("pipeline moved while stalled");

endmodule

// ----- tb/matrix_3x3_inverse_test.sv -----
`timescale 1ns / 1ps

module matrix_3x3_inverse_test;
    import m3i_pkg::*;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic [OUT_W-1:0] qout_t;

    typedef struct packed {
        qout_t [NELEM-1:0] inv;
        logic              singular;
    } inverse_t;

    class inverse_scoreboard;
        inverse_t pending[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // adj * 2^24 / det, nearest with ties away from zero, saturated
        function qout_t scaled_quotient(longint adj, longint det);
            bit          neg;
            logic [63:0] num, den, q;
            neg = (adj < 0) != (det < 0);
            num = (adj < 0 ? -adj : adj) << FRAC_SH;
            den = det < 0 ? -det : det;
            q   = (num + (den >> 1)) / den;
            if (neg)
                return (q > 64'h8000_0000) ? SAT_NEG : qout_t'(-q);
            return (q > 64'h7FFF_FFFF) ? SAT_POS : qout_t'(q);
        endfunction

        function void note_request(logic [NELEM*ELEM_W-1:0] data);
            longint   a[NELEM];
            longint   adj[NELEM];
            longint   det;
            inverse_t res;
            for (int k = 0; k < NELEM; k++)
                a[k] = longint'(elem_t'(data[k*ELEM_W +: ELEM_W]));
            adj[0] = a[4]*a[8] - a[5]*a[7];
            adj[1] = -(a[1]*a[8] - a[2]*a[7]);
            adj[2] = a[1]*a[5] - a[2]*a[4];
            adj[3] = -(a[3]*a[8] - a[5]*a[6]);
            adj[4] = a[0]*a[8] - a[2]*a[6];
            adj[5] = -(a[0]*a[5] - a[2]*a[3]);
            adj[6] = a[3]*a[7] - a[4]*a[6];
            adj[7] = -(a[0]*a[7] - a[1]*a[6]);
            adj[8] = a[0]*a[4] - a[1]*a[3];
            det = adj[0]*a[0] + adj[3]*a[1] + adj[6]*a[2];
            res = '0;
            if (det == 0) begin
                res.singular = 1'b1;
            end else begin
                for (int k = 0; k < NELEM; k++)
                    res.inv[k] = scaled_quotient(adj[k], det);
            end
            pending.push_back(res);
        endfunction

        function void check_result(logic [NELEM*OUT_W-1:0] data, logic sing);
            inverse_t exp_res;
            if (pending.size() == 0) begin
                $error("result with nothing pending: singular=%0b", sing);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            for (int k = 0; k < NELEM; k++)
                if (data[k*OUT_W +: OUT_W] !== exp_res.inv[k]) begin
                    $error("inv%0d%0d: expected %h, got %h", k / 3, k % 3,
                           exp_res.inv[k], data[k*OUT_W +: OUT_W]);
                    errors++;
                end
            if (sing !== exp_res.singular) begin
                $error("singular: expected %0b, got %0b", exp_res.singular, sing);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY   = 41;
    localparam int WATCHDOG  = 5000;
    localparam int N_RANDOM  = 1500;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [NELEM*ELEM_W-1:0] s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [NELEM*OUT_W-1:0]  m_tdata;
    logic                    m_tuser;

    inverse_scoreboard board;
    int  idle_cycles;

    matrix_3x3_inverse dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic elem_t random_elem();
        case ($urandom_range(0, 5))
            0: return elem_t'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7FFF);
            1: return elem_t'(int'($urandom_range(0, 4)) - 2);
            2: return elem_t'($signed($urandom_range(0, 1023)) - 512);
            default: return elem_t'($urandom());
        endcase
    endfunction

    // drive one request and hold it until taken
    task automatic send_matrix(input logic [NELEM*ELEM_W-1:0] data);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        board.note_request(data);
    endtask

    task automatic send_elems(input elem_t e[NELEM]);
        logic [NELEM*ELEM_W-1:0] d;
        for (int k = 0; k < NELEM; k++) d[k*ELEM_W +: ELEM_W] = e[k];
        send_matrix(d);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    // sink side: random stalls, accepted result checked at the edge
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = gap_length();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_result(m_tdata, m_tuser);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        elem_t e[NELEM];
        logic [NELEM*ELEM_W-1:0] d;
        board = new();
        idle_cycles = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity, scaled identity, all extremes, zero, singular rows
        e = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100};
        send_elems(e);
        e = '{16'sh0001, 0, 0, 0, 16'sh0001, 0, 0, 0, 16'sh0001};
        send_elems(e);
        e = '{16'sh7FFF, 0, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh7FFF};
        send_elems(e);
        e = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
        send_elems(e);
        e = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
              16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF};
        send_elems(e);
        send_matrix('0);
        send_matrix('1);
        e = '{1, 2, 3, 2, 4, 6, 7, 8, 9};
        send_elems(e);
        e = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
              16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
        send_elems(e);
        // rounding: 1/2 and -1/2 style quotients
        e = '{2, 0, 0, 0, 1, 0, 0, 0, 1};
        send_elems(e);
        e = '{-2, 0, 0, 0, 1, 0, 0, 0, 1};
        send_elems(e);
        e = '{3, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100};
        send_elems(e);
        e = '{-3, 1, 0, 0, 16'sh7FFF, 0, 0, 0, 1};
        send_elems(e);
        e = '{16'sh0200, 16'sh0100, 0, 16'sh0100, 16'sh0300, 16'sh0100,
              0, 16'sh0100, 16'sh0400};
        send_elems(e);
        e = '{0, 16'sh0100, 0, 0, 0, 16'sh0100, 16'sh0100, 0, 0};
        send_elems(e);
        e = '{0, -1, 0, 0, 0, 1, 1, 0, 0};
        send_elems(e);
        wait_drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            for (int k = 0; k < NELEM; k++)
                d[k*ELEM_W +: ELEM_W] = (i % 4 == 0) ? elem_t'($urandom())
                                                     : random_elem();
            send_matrix(d);
            if (i == N_RANDOM / 2) wait_drain();
        end
        wait_drain();
        repeat (LATENCY + 10) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- matrix_3x3_inverse.f -----
src/m3i_pkg.sv
src/m3i_div.sv
src/matrix_3x3_inverse.sv
tb/matrix_3x3_inverse_test.sv
